// ===== design/cpin_pkg.sv =====
// Shared constants, types and helpers for the circle pair intersect block.
package cpin_pkg;

  localparam int FracBits   = 16;
  localparam int ThrW       = 16;
  localparam int CoordW     = 32;
  localparam int RadW       = 31;
  localparam int NumW       = 64;
  localparam int SqrtSteps  = 32;
  localparam int RootW      = SqrtSteps + 1;
  localparam int QuotW      = 41;
  localparam int QuotCapLog = 40;
  localparam int AmagW      = 32;
  localparam int AddrW      = 2;

  // round(0.0001 * 2^FracBits)
  localparam logic [ThrW-1:0] ThreshReset =
    ThrW'(((64'd1 << FracBits) + 64'd5000) / 64'd10000);

  localparam logic [AddrW-1:0] AddrThresh = '0;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatNoIsect = 2'd1,
    StatCoinc   = 2'd2
  } stat_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] gx;
    logic signed [CoordW-1:0] gy;
    logic [CoordW-1:0]        ux;
    logic [CoordW-1:0]        uy;
    logic                     nx;
    logic                     ny;
    stat_e                    status;
  } geo_t;

  typedef struct packed {
    geo_t               geo;
    logic [2*RadW-1:0]  r1s;
    logic [2*RadW-1:0]  r2s;
    logic [NumW-1:0]    d2;
  } sd_side_t;

  typedef struct packed {
    geo_t               geo;
    logic [2*RadW-1:0]  r1s;
    logic [RootW-1:0]   d;
    logic               nn;
  } da_side_t;

  typedef struct packed {
    geo_t               geo;
    logic [RootW-1:0]   d;
    logic               nn;
    logic [NumW-1:0]    aux;
    logic [NumW-1:0]    auy;
  } sh_side_t;

  typedef struct packed {
    logic neg;
    geo_t geo;
  } dv_side_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    stat_e                    status;
  } res_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

// ===== design/cpin_if.sv =====
// Item channels: measurement input and position result.
interface cpin_in_if import cpin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] centre_one_x;
  logic signed [CoordW-1:0] centre_one_y;
  logic [RadW-1:0]          radius_one;
  logic signed [CoordW-1:0] centre_two_x;
  logic signed [CoordW-1:0] centre_two_y;
  logic [RadW-1:0]          radius_two;
  logic signed [CoordW-1:0] guess_x;
  logic signed [CoordW-1:0] guess_y;

  modport source (output valid, centre_one_x, centre_one_y, radius_one,
                  centre_two_x, centre_two_y, radius_two, guess_x, guess_y,
                  input ready);
  modport sink (input valid, centre_one_x, centre_one_y, radius_one,
                centre_two_x, centre_two_y, radius_two, guess_x, guess_y,
                output ready);
endinterface

interface cpin_out_if import cpin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] position_x;
  logic signed [CoordW-1:0] position_y;
  stat_e                    status;

  modport source (output valid, position_x, position_y, status, input ready);
  modport sink (input valid, position_x, position_y, status, output ready);
endinterface

// ===== design/cpin_sqrt.sv =====
// Pipelined square root, one result bit per stage, rounded to nearest.
module cpin_sqrt import cpin_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*SqrtSteps-1:0] rad_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output logic [RootW-1:0]      root_o,
  output logic [SideW-1:0]      side_o
);

  localparam int VW = 2 * SqrtSteps;

  logic [VW-1:0]        rem_q  [SqrtSteps];
  logic [SqrtSteps-1:0] root_q [SqrtSteps];
  logic                 vld_q  [SqrtSteps];
  logic [SideW-1:0]     side_q [SqrtSteps];

  logic                 out_v_q;
  logic [RootW-1:0]     out_root_q;
  logic [SideW-1:0]     out_side_q;

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
    localparam int K = SqrtSteps - 1 - s;
    logic [VW-1:0]        rem_in;
    logic [SqrtSteps-1:0] root_in;
    logic                 vld_in;
    logic [SideW-1:0]     side_in;
    logic [VW:0]          trial;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (R + 2^K)^2 - R^2 with R holding only bits above K
    assign trial = ((VW+1)'(root_in) << (K + 1)) | ((VW+1)'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_q[s]  <= rem_in - VW'(trial);
          root_q[s] <= root_in | (SqrtSteps'(1) << K);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= vld_q[SqrtSteps-1];
    end
  end

  // remainder above the floor root means the upper neighbor is nearer
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_side_q <= side_q[SqrtSteps-1];
      if (rem_q[SqrtSteps-1] > VW'(root_q[SqrtSteps-1])) begin
        out_root_q <= RootW'(root_q[SqrtSteps-1]) + RootW'(1);
      end else begin
        out_root_q <= RootW'(root_q[SqrtSteps-1]);
      end
    end
  end

  assign valid_o = out_v_q;
  assign root_o  = out_root_q;
  assign side_o  = out_side_q;

endmodule

// ===== design/cpin_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round half up.
module cpin_div import cpin_pkg::*; #(
  parameter int DenW  = 34,
  parameter int QW    = 32,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QW:0]      quot_o,
  output logic             ovf_o,
  output logic [SideW-1:0] side_o
);

  localparam int CmpW = (NumW > DenW + QW) ? NumW : DenW + QW;

  // entry stage: quotient too wide for QW bits
  logic             pre_v_q;
  logic [NumW-1:0]  pre_num_q;
  logic [DenW-1:0]  pre_den_q;
  logic             pre_ovf_q;
  logic [SideW-1:0] pre_side_q;

  logic [NumW-1:0]  rem_q  [QW];
  logic [QW-1:0]    quo_q  [QW];
  logic [DenW-1:0]  den_q  [QW];
  logic             ovf_q  [QW];
  logic             vld_q  [QW];
  logic [SideW-1:0] side_q [QW];

  logic             out_v_q;
  logic [QW:0]      out_quot_q;
  logic             out_ovf_q;
  logic [SideW-1:0] out_side_q;
  logic             rnd_up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      pre_v_q <= valid_i;
      out_v_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_num_q  <= num_i;
      pre_den_q  <= den_i;
      pre_side_q <= side_i;
      pre_ovf_q  <= CmpW'(num_i) >= (CmpW'(den_i) << QW);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [NumW-1:0]  rem_in;
    logic [QW-1:0]    quo_in;
    logic [DenW-1:0]  den_in;
    logic             ovf_in;
    logic             vld_in;
    logic [SideW-1:0] side_in;
    logic [CmpW-1:0]  trial;

    if (s == 0) begin : g_first
      assign rem_in  = pre_num_q;
      assign quo_in  = '0;
      assign den_in  = pre_den_q;
      assign ovf_in  = pre_ovf_q;
      assign vld_in  = pre_v_q;
      assign side_in = pre_side_q;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign ovf_in  = ovf_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = CmpW'(den_in) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        ovf_q[s]  <= ovf_in;
        side_q[s] <= side_in;
        if (CmpW'(rem_in) >= trial) begin
          rem_q[s] <= rem_in - NumW'(trial);
          quo_q[s] <= quo_in | (QW'(1) << K);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  // half away from zero: 2*rem >= den
  assign rnd_up = {rem_q[QW-1][DenW-1:0], 1'b0} >= {1'b0, den_q[QW-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_quot_q <= (QW+1)'(quo_q[QW-1]) + (QW+1)'(rnd_up);
      out_ovf_q  <= ovf_q[QW-1];
      out_side_q <= side_q[QW-1];
    end
  end

  assign valid_o = out_v_q;
  assign quot_o  = out_quot_q;
  assign ovf_o   = out_ovf_q;
  assign side_o  = out_side_q;

endmodule

// ===== design/circle_pair_intersect_nearest.sv =====
// Two-circle trilateration: intersection point nearest a guessed position.
//
// Usage: an item on item_i carries two circles (centre, radius) and a
// guess; centres and guess are signed Q16.16, radii unsigned Q15.16. One
// result leaves on result_o: the crossing point nearer the guess (ties to
// the first point) and a status code. Separate or nested circles give
// StatNoIsect, centres closer than the coincident_threshold register give
// StatCoinc; both return zero coords. The threshold sits at APB byte
// address 0; the user must write it while idle, which is not enforced.
// Throughput: one item per cycle while the skid is empty. The path from
// accept to result valid runs through two 33-stage root pipelines and two
// bit-per-stage dividers (34 and 43 stages) in series.
// Every stage moves on one enable; a two-entry output buffer (result
// register plus skid) keeps item_i.ready registered, so items are still
// taken while one result waits, and the pipe only freezes once the skid
// is full. Nothing is dropped or repeated across a stall.
// Reset clears all valid bits and loads the threshold with its default.
module circle_pair_intersect_nearest import cpin_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cpin_in_if.sink           item_i,
  cpin_out_if.source        result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic en;
  logic [ThrW-1:0] thr_q;

  // ---------------- config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThreshReset;
    end else if (psel && penable && pwrite && paddr == AddrThresh) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrThresh) ? 32'(thr_q) : '0;

  // ---------------- helpers
  function automatic logic [CoordW-1:0] absd(input logic signed [CoordW:0] v);
    return v[CoordW] ? CoordW'(-v) : v[CoordW-1:0];
  endfunction

  function automatic logic signed [QuotW:0] signq(input logic [QuotW:0] q,
                                                   input logic ovf, input logic neg);
    logic [QuotW:0]        qc;
    logic signed [QuotW:0] v;
    qc = (ovf || q > ((QuotW+1)'(1) << QuotCapLog)) ? ((QuotW+1)'(1) << QuotCapLog) : q;
    v  = $signed(qc);
    return neg ? -v : v;
  endfunction

  // ---------------- stage A: differences and radius sum/difference
  logic                  a_v_q;
  geo_t                  a_geo_d, a_geo_q;
  logic signed [CoordW:0] a_dx, a_dy;
  logic [RadW-1:0]       a_r1_q, a_r2_q, a_rd_d, a_rd_q;
  logic [CoordW-1:0]     a_rs_q;

  always_comb begin
    a_dx = (CoordW+1)'(item_i.centre_two_x) - (CoordW+1)'(item_i.centre_one_x);
    a_dy = (CoordW+1)'(item_i.centre_two_y) - (CoordW+1)'(item_i.centre_one_y);
    a_geo_d.x1     = item_i.centre_one_x;
    a_geo_d.y1     = item_i.centre_one_y;
    a_geo_d.gx     = item_i.guess_x;
    a_geo_d.gy     = item_i.guess_y;
    a_geo_d.ux     = absd(a_dx);
    a_geo_d.uy     = absd(a_dy);
    a_geo_d.nx     = a_dx[CoordW];
    a_geo_d.ny     = a_dy[CoordW];
    a_geo_d.status = StatOk;
    a_rd_d = (item_i.radius_one > item_i.radius_two) ?
             item_i.radius_one - item_i.radius_two : item_i.radius_two - item_i.radius_one;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_geo_q <= a_geo_d;
      a_r1_q  <= item_i.radius_one;
      a_r2_q  <= item_i.radius_two;
      a_rs_q  <= CoordW'(item_i.radius_one) + CoordW'(item_i.radius_two);
      a_rd_q  <= a_rd_d;
    end
  end

  // ---------------- stage B: squares
  logic              b_v_q;
  geo_t              b_geo_q;
  logic [NumW-1:0]   b_sx_q, b_sy_q, b_rs2_q;
  logic [2*RadW-1:0] b_r1s_q, b_r2s_q, b_rd2_q;
  logic [2*ThrW-1:0] b_thr2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_geo_q  <= a_geo_q;
      b_sx_q   <= NumW'(a_geo_q.ux) * NumW'(a_geo_q.ux);
      b_sy_q   <= NumW'(a_geo_q.uy) * NumW'(a_geo_q.uy);
      b_rs2_q  <= NumW'(a_rs_q) * NumW'(a_rs_q);
      b_r1s_q  <= (2*RadW)'(a_r1_q) * (2*RadW)'(a_r1_q);
      b_r2s_q  <= (2*RadW)'(a_r2_q) * (2*RadW)'(a_r2_q);
      b_rd2_q  <= (2*RadW)'(a_rd_q) * (2*RadW)'(a_rd_q);
      b_thr2_q <= (2*ThrW)'(thr_q) * (2*ThrW)'(thr_q);
    end
  end

  // ---------------- stage C: squared centre distance and classification
  logic            c_v_q;
  sd_side_t        c_side_d, c_side_q;
  logic [NumW:0]   c_d2;

  always_comb begin
    c_d2 = (NumW+1)'(b_sx_q) + (NumW+1)'(b_sy_q);
    c_side_d.geo = b_geo_q;
    c_side_d.r1s = b_r1s_q;
    c_side_d.r2s = b_r2s_q;
    c_side_d.d2  = c_d2[NumW-1:0];
    // nesting test ranks ahead of the coincident test
    if (c_d2 > (NumW+1)'(b_rs2_q) || c_d2 < (NumW+1)'(b_rd2_q)) begin
      c_side_d.geo.status = StatNoIsect;
    end else if (c_d2 == '0 || c_d2 < (NumW+1)'(b_thr2_q)) begin
      c_side_d.geo.status = StatCoinc;
    end else begin
      c_side_d.geo.status = StatOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q <= c_side_d;
    end
  end

  // ---------------- d = sqrt(D2)
  logic             sd_v;
  logic [RootW-1:0] sd_root;
  sd_side_t         sd_side;

  cpin_sqrt #(.SideW($bits(sd_side_t))) u_sqrt_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .rad_i   (c_side_q.d2),
    .side_i  (c_side_q),
    .valid_o (sd_v),
    .root_o  (sd_root),
    .side_o  (sd_side)
  );

  // ---------------- stage D: numerator r1^2 - r2^2 + D2 as sign/magnitude
  logic            d_v_q;
  da_side_t        d_side_d, d_side_q;
  logic [NumW-1:0] d_nmag_d, d_nmag_q, d_t;
  logic [RootW:0]  d_den_q;

  always_comb begin
    d_t = NumW'(sd_side.r2s) - sd_side.d2;
    d_side_d.geo = sd_side.geo;
    d_side_d.r1s = sd_side.r1s;
    d_side_d.d   = sd_root;
    d_side_d.nn  = 1'b0;
    if (sd_side.d2 >= NumW'(sd_side.r2s)) begin
      d_nmag_d = (sd_side.d2 - NumW'(sd_side.r2s)) + NumW'(sd_side.r1s);
    end else if (NumW'(sd_side.r1s) >= d_t) begin
      d_nmag_d = NumW'(sd_side.r1s) - d_t;
    end else begin
      d_nmag_d    = d_t - NumW'(sd_side.r1s);
      d_side_d.nn = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_side_q <= d_side_d;
      d_nmag_q <= d_nmag_d;
      d_den_q  <= {sd_root, 1'b0};
    end
  end

  // ---------------- a = nmag / 2d
  logic           da_v, da_ovf;
  logic [AmagW:0] da_quot;
  da_side_t       da_side;

  cpin_div #(.DenW(RootW + 1), .QW(AmagW), .SideW($bits(da_side_t))) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_v_q),
    .num_i   (d_nmag_q),
    .den_i   (d_den_q),
    .side_i  (d_side_q),
    .valid_o (da_v),
    .quot_o  (da_quot),
    .ovf_o   (da_ovf),
    .side_o  (da_side)
  );

  // ---------------- stage E: saturate a, products with a
  logic              e_v_q;
  logic [AmagW-1:0]  e_amag;
  da_side_t          e_side_q;
  logic [NumW-1:0]   e_a2_q, e_aux_q, e_auy_q;

  assign e_amag = (da_ovf || da_quot[AmagW]) ? '1 : da_quot[AmagW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_side_q <= da_side;
      e_a2_q   <= NumW'(e_amag) * NumW'(e_amag);
      e_aux_q  <= NumW'(e_amag) * NumW'(da_side.geo.ux);
      e_auy_q  <= NumW'(e_amag) * NumW'(da_side.geo.uy);
    end
  end

  // ---------------- stage F: h^2 = |r1^2 - a^2|
  logic            f_v_q;
  sh_side_t        f_side_q;
  logic [NumW-1:0] f_h2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_side_q.geo <= e_side_q.geo;
      f_side_q.d   <= e_side_q.d;
      f_side_q.nn  <= e_side_q.nn;
      f_side_q.aux <= e_aux_q;
      f_side_q.auy <= e_auy_q;
      f_h2_q <= (NumW'(e_side_q.r1s) >= e_a2_q) ? NumW'(e_side_q.r1s) - e_a2_q
                                                 : e_a2_q - NumW'(e_side_q.r1s);
    end
  end

  // ---------------- h = sqrt(h^2)
  logic             sh_v;
  logic [RootW-1:0] sh_root;
  sh_side_t         sh_side;

  cpin_sqrt #(.SideW($bits(sh_side_t))) u_sqrt_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v_q),
    .rad_i   (f_h2_q),
    .side_i  (f_side_q),
    .valid_o (sh_v),
    .root_o  (sh_root),
    .side_o  (sh_side)
  );

  // ---------------- stage G: products with saturated h
  logic              g_v_q;
  logic [CoordW-1:0] g_hs;
  sh_side_t          g_side_q;
  logic [NumW-1:0]   g_hux_q, g_huy_q;
  dv_side_t          g_dva_side;

  assign g_hs = sh_root[RootW-1] ? '1 : sh_root[CoordW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_side_q <= sh_side;
      g_hux_q  <= NumW'(g_hs) * NumW'(sh_side.geo.ux);
      g_huy_q  <= NumW'(g_hs) * NumW'(sh_side.geo.uy);
    end
  end

  assign g_dva_side.neg = g_side_q.nn ^ g_side_q.geo.nx;
  assign g_dva_side.geo = g_side_q.geo;

  // ---------------- four quotients over d: a*dx, a*dy, h*dy, h*dx
  logic           dva_v, dvb_v, dvc_v, dvd_v;
  logic           dva_ovf, dvb_ovf, dvc_ovf, dvd_ovf;
  logic [QuotW:0] dva_q, dvb_q, dvc_q, dvd_q;
  dv_side_t       dva_side;
  logic           dvb_neg, dvc_neg, dvd_neg;

  cpin_div #(.DenW(RootW), .QW(QuotW), .SideW($bits(dv_side_t))) u_div_cx (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (g_v_q),
    .num_i (g_side_q.aux), .den_i (g_side_q.d), .side_i (g_dva_side),
    .valid_o (dva_v), .quot_o (dva_q), .ovf_o (dva_ovf), .side_o (dva_side)
  );

  cpin_div #(.DenW(RootW), .QW(QuotW), .SideW(1)) u_div_cy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (g_v_q),
    .num_i (g_side_q.auy), .den_i (g_side_q.d),
    .side_i (g_side_q.nn ^ g_side_q.geo.ny),
    .valid_o (dvb_v), .quot_o (dvb_q), .ovf_o (dvb_ovf), .side_o (dvb_neg)
  );

  cpin_div #(.DenW(RootW), .QW(QuotW), .SideW(1)) u_div_fx (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (g_v_q),
    .num_i (g_huy_q), .den_i (g_side_q.d), .side_i (g_side_q.geo.ny),
    .valid_o (dvc_v), .quot_o (dvc_q), .ovf_o (dvc_ovf), .side_o (dvc_neg)
  );

  cpin_div #(.DenW(RootW), .QW(QuotW), .SideW(1)) u_div_fy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (g_v_q),
    .num_i (g_hux_q), .den_i (g_side_q.d), .side_i (g_side_q.geo.nx),
    .valid_o (dvd_v), .quot_o (dvd_q), .ovf_o (dvd_ovf), .side_o (dvd_neg)
  );

  // ---------------- stage H: chord midpoint and offset
  logic                     h_v_q;
  geo_t                     h_geo_q;
  logic signed [QuotW+1:0]  h_cx_q, h_cy_q;
  logic signed [QuotW:0]    h_fx_q, h_fy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_geo_q <= dva_side.geo;
      h_cx_q  <= (QuotW+2)'(dva_side.geo.x1) + (QuotW+2)'(signq(dva_q, dva_ovf, dva_side.neg));
      h_cy_q  <= (QuotW+2)'(dva_side.geo.y1) + (QuotW+2)'(signq(dvb_q, dvb_ovf, dvb_neg));
      h_fx_q  <= signq(dvc_q, dvc_ovf, dvc_neg);
      h_fy_q  <= signq(dvd_q, dvd_ovf, dvd_neg);
    end
  end

  // ---------------- stage I: both candidate points, saturated
  logic                     i_v_q;
  geo_t                     i_geo_q;
  logic signed [CoordW-1:0] i_p1x_q, i_p1y_q, i_p2x_q, i_p2y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_geo_q <= h_geo_q;
      i_p1x_q <= sat32(44'(h_cx_q) + 44'(h_fx_q));
      i_p1y_q <= sat32(44'(h_cy_q) - 44'(h_fy_q));
      i_p2x_q <= sat32(44'(h_cx_q) - 44'(h_fx_q));
      i_p2y_q <= sat32(44'(h_cy_q) + 44'(h_fy_q));
    end
  end

  // ---------------- stage J: distances to the guess
  logic                     j_v_q;
  stat_e                    j_status_q;
  logic signed [CoordW-1:0] j_p1x_q, j_p1y_q, j_p2x_q, j_p2y_q;
  logic [CoordW-1:0]        j_e1x_q, j_e1y_q, j_e2x_q, j_e2y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_status_q <= i_geo_q.status;
      j_p1x_q <= i_p1x_q;
      j_p1y_q <= i_p1y_q;
      j_p2x_q <= i_p2x_q;
      j_p2y_q <= i_p2y_q;
      j_e1x_q <= absd((CoordW+1)'(i_p1x_q) - (CoordW+1)'(i_geo_q.gx));
      j_e1y_q <= absd((CoordW+1)'(i_p1y_q) - (CoordW+1)'(i_geo_q.gy));
      j_e2x_q <= absd((CoordW+1)'(i_p2x_q) - (CoordW+1)'(i_geo_q.gx));
      j_e2y_q <= absd((CoordW+1)'(i_p2y_q) - (CoordW+1)'(i_geo_q.gy));
    end
  end

  // ---------------- stage K: squared distance terms
  logic                     k_v_q;
  stat_e                    k_status_q;
  logic signed [CoordW-1:0] k_p1x_q, k_p1y_q, k_p2x_q, k_p2y_q;
  logic [NumW-1:0]          k_q1x_q, k_q1y_q, k_q2x_q, k_q2y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_status_q <= j_status_q;
      k_p1x_q <= j_p1x_q;
      k_p1y_q <= j_p1y_q;
      k_p2x_q <= j_p2x_q;
      k_p2y_q <= j_p2y_q;
      k_q1x_q <= NumW'(j_e1x_q) * NumW'(j_e1x_q);
      k_q1y_q <= NumW'(j_e1y_q) * NumW'(j_e1y_q);
      k_q2x_q <= NumW'(j_e2x_q) * NumW'(j_e2x_q);
      k_q2y_q <= NumW'(j_e2y_q) * NumW'(j_e2y_q);
    end
  end

  // ---------------- stage L: pick the nearer point (tie keeps point one), zeros on error
  logic [NumW:0] l_s1, l_s2;
  res_t          arr_res;
  logic          arr;

  always_comb begin
    l_s1 = (NumW+1)'(k_q1x_q) + (NumW+1)'(k_q1y_q);
    l_s2 = (NumW+1)'(k_q2x_q) + (NumW+1)'(k_q2y_q);
    arr_res.status = k_status_q;
    if (k_status_q != StatOk) begin
      arr_res.x = '0;
      arr_res.y = '0;
    end else if (l_s1 > l_s2) begin
      arr_res.x = k_p2x_q;
      arr_res.y = k_p2y_q;
    end else begin
      arr_res.x = k_p1x_q;
      arr_res.y = k_p1y_q;
    end
  end

  assign arr = en & k_v_q;

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      k_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= item_i.valid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= sd_v;
      e_v_q <= da_v;
      f_v_q <= e_v_q;
      g_v_q <= sh_v;
      h_v_q <= dva_v;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
      k_v_q <= j_v_q;
    end
  end

  // ---------------- output register plus skid
  logic out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic out_ld_skid, out_ld_arr, skid_ld, pop;
  res_t out_res_q, skid_res_q;

  assign en  = ~skid_v_q;
  assign pop = out_v_q & result_o.ready;

  always_comb begin
    out_v_d     = out_v_q;
    skid_v_d    = skid_v_q;
    out_ld_skid = 1'b0;
    out_ld_arr  = 1'b0;
    skid_ld     = 1'b0;
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_v_d     = 1'b1;
        out_ld_skid = 1'b1;
        skid_v_d    = 1'b0;
      end else begin
        out_v_d    = arr;
        out_ld_arr = arr;
      end
    end else if (arr) begin
      skid_v_d = 1'b1;
      skid_ld  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld_skid) begin
      out_res_q <= skid_res_q;
    end else if (out_ld_arr) begin
      out_res_q <= arr_res;
    end
    if (skid_ld) begin
      skid_res_q <= arr_res;
    end
  end

  assign item_i.ready      = en;
  assign result_o.valid      = out_v_q;
  assign result_o.position_x = out_res_q.x;
  assign result_o.position_y = out_res_q.y;
  assign result_o.status     = out_res_q.status;

  // ---------------- assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while the result register is empty");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dva_v == dvb_v) && (dva_v == dvc_v) && (dva_v == dvd_v))
    else $error("parallel dividers out of step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status != StatOk) |->
      (result_o.position_x == '0 && result_o.position_y == '0))
    else $error("error result with nonzero coordinates");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !result_o.ready) |=> skid_v_q)
    else $error("skid item lost during stall");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the circle pair intersect nearest block.
module tb_top;
  import cpin_pkg::*;

  // One measurement set as it enters the block.
  typedef struct {
    logic signed [CoordW-1:0] c1x;
    logic signed [CoordW-1:0] c1y;
    logic [RadW-1:0]          r1;
    logic signed [CoordW-1:0] c2x;
    logic signed [CoordW-1:0] c2y;
    logic [RadW-1:0]          r2;
    logic signed [CoordW-1:0] gx;
    logic signed [CoordW-1:0] gy;
  } meas_t;

  // One expected position fix.
  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    stat_e                    status;
  } fix_t;

  localparam longint One = 64'sd65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Config port
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  cpin_in_if  in_if ();
  cpin_out_if out_if ();

  circle_pair_intersect_nearest i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Testbench copy of the threshold register.
  logic [ThrW-1:0] thresh_q = ThreshReset;

  fix_t fix_queue[$];
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_coinc = 0;
  int   n_noisect = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.centre_one_x = '0;
    in_if.centre_one_y = '0;
    in_if.radius_one = '0;
    in_if.centre_two_x = '0;
    in_if.centre_two_y = '0;
    in_if.radius_two = '0;
    in_if.guess_x = '0;
    in_if.guess_y = '0;
    out_if.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor arithmetic. All magnitudes live in 64-bit unsigned words that
  // wrap the same way the datapath spec says (d2 carry is detected by d2 < dx^2).
  // ---------------------------------------------------------------------------

  // Integer square root rounded to nearest.
  function automatic logic [63:0] root_near(logic [63:0] v);
    logic [63:0] res, step, rem, r;
    res = '0;
    step = 64'd1 << 62;
    rem = v;
    while (step > rem) step = step >> 2;
    while (step != 0) begin
      if (rem >= res + step) begin
        rem = rem - (res + step);
        res = (res >> 1) + step;
      end else begin
        res = res >> 1;
      end
      step = step >> 2;
    end
    r = res;
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  // Unsigned divide, half rounds up.
  function automatic logic [63:0] quot_round(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, rem;
    q = num / den;
    rem = num % den;
    if (rem >= den - rem) q = q + 1;
    return q;
  endfunction

  // Signed quotient from magnitude and sign, capped at 2^40.
  function automatic longint quot_signed(logic [63:0] mag, logic neg, logic [63:0] den);
    logic [63:0] q;
    q = quot_round(mag, den);
    if (q > (64'd1 << QuotCapLog)) q = 64'd1 << QuotCapLog;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Squared distance as {carry, low word}.
  function automatic logic [64:0] dist_sq(longint px, longint py, longint gx, longint gy);
    longint ex, ey;
    logic [63:0] ax, ay, sx, s;
    ex = px - gx;
    ey = py - gy;
    ax = (ex < 0) ? 64'(-ex) : 64'(ex);
    ay = (ey < 0) ? 64'(-ey) : 64'(ey);
    sx = ax * ax;
    s = sx + ay * ay;
    return {(s < sx), s};
  endfunction

  function automatic fix_t predict_fix(meas_t m);
    fix_t f;
    longint x1, y1, x2, y2, gx, gy, dxs, dys, cx, cy, fx, fy, p1x, p1y, p2x, p2y;
    logic [63:0] r1, r2, ux, uy, sx, d2, rs, rd, d, r1s, r2s, nmag, amag, h2, h, thr;
    logic nx, ny, nn;
    logic [64:0] e1, e2;
    x1 = longint'(m.c1x);
    y1 = longint'(m.c1y);
    x2 = longint'(m.c2x);
    y2 = longint'(m.c2y);
    gx = longint'(m.gx);
    gy = longint'(m.gy);
    r1 = 64'(m.r1);
    r2 = 64'(m.r2);
    dxs = x2 - x1;
    dys = y2 - y1;
    nx = dxs < 0;
    ny = dys < 0;
    ux = nx ? 64'(-dxs) : 64'(dxs);
    uy = ny ? 64'(-dys) : 64'(dys);
    sx = ux * ux;
    d2 = sx + uy * uy;
    rs = r1 + r2;
    rd = (r1 > r2) ? r1 - r2 : r2 - r1;
    r1s = r1 * r1;
    r2s = r2 * r2;
    thr = 64'(thresh_q);
    nn = 1'b0;
    f.x = '0;
    f.y = '0;
    // Carry out of d2, separate circles, nested circles.
    if (d2 < sx || d2 > rs * rs || d2 < rd * rd) begin
      f.status = StatNoIsect;
      return f;
    end
    // Equal centres that pass the checks above count, even with a zero threshold.
    if (d2 == 0 || d2 < thr * thr) begin
      f.status = StatCoinc;
      return f;
    end
    d = root_near(d2);
    if (d2 >= r2s) begin
      nmag = (d2 - r2s) + r1s;
    end else if (r1s >= r2s - d2) begin
      nmag = r1s - (r2s - d2);
    end else begin
      nmag = (r2s - d2) - r1s;
      nn = 1'b1;
    end
    amag = quot_round(nmag, 2 * d);
    if (amag > 64'hFFFF_FFFF) amag = 64'hFFFF_FFFF;
    h2 = (r1s >= amag * amag) ? r1s - amag * amag : amag * amag - r1s;
    h = root_near(h2);
    if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
    cx = x1 + quot_signed(amag * ux, nn != nx, d);
    cy = y1 + quot_signed(amag * uy, nn != ny, d);
    fx = quot_signed(h * uy, ny, d);
    fy = quot_signed(h * ux, nx, d);
    p1x = clamp_coord(cx + fx);
    p1y = clamp_coord(cy - fy);
    p2x = clamp_coord(cx - fx);
    p2y = clamp_coord(cy + fy);
    e1 = dist_sq(p1x, p1y, gx, gy);
    e2 = dist_sq(p2x, p2y, gx, gy);
    // Tie keeps point one.
    if (e1 > e2) begin
      p1x = p2x;
      p1y = p2y;
    end
    f.x = p1x[31:0];
    f.y = p1y[31:0];
    f.status = StatOk;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern plus the long hold-off, and the checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    fix_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (fix_queue.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: result with nothing pending x=%h y=%h st=%0d",
                   out_if.position_x, out_if.position_y, out_if.status);
      end else begin
        want = fix_queue.pop_front();
        n_checked++;
        if (out_if.position_x !== want.x || out_if.position_y !== want.y ||
            out_if.status !== want.status) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: fix %0d exp x=%h y=%h st=%0d got x=%h y=%h st=%0d",
                     n_checked, want.x, want.y, want.status,
                     out_if.position_x, out_if.position_y, out_if.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and config port.
  // ---------------------------------------------------------------------------

  // Offers one item, idling first at the current rate; valid stays high after
  // acceptance so back-to-back items never drop it.
  task automatic send_meas(meas_t m);
    fix_t f;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.centre_one_x <= m.c1x;
    in_if.centre_one_y <= m.c1y;
    in_if.radius_one <= m.r1;
    in_if.centre_two_x <= m.c2x;
    in_if.centre_two_y <= m.c2y;
    in_if.radius_two <= m.r2;
    in_if.guess_x <= m.gx;
    in_if.guess_y <= m.gy;
    do @(posedge clk_i); while (!in_if.ready);
    f = predict_fix(m);
    if (f.status == StatCoinc) n_coinc++;
    if (f.status == StatNoIsect) n_noisect++;
    fix_queue.push_back(f);
    n_sent++;
  endtask

  // Drops valid and waits until every fix has come back.
  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (fix_queue.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [ThrW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrThresh;
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    thresh_q = val;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[ThrW-1:0] !== val) begin
      n_errors++;
      if (n_errors <= 10) $display("ERROR: threshold readback exp %h got %h", val, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic meas_t mk(longint c1x, longint c1y, longint r1, longint c2x,
                               longint c2y, longint r2, longint gx, longint gy);
    meas_t m;
    m.c1x = c1x[31:0];
    m.c1y = c1y[31:0];
    m.r1 = r1[30:0];
    m.c2x = c2x[31:0];
    m.c2y = c2y[31:0];
    m.r2 = r2[30:0];
    m.gx = gx[31:0];
    m.gy = gy[31:0];
    return m;
  endfunction

  function automatic real rnd_span(real s);
    return ($urandom / 4294967296.0 * 2.0 - 1.0) * s;
  endfunction

  // Circles built around a common point, so they nearly always cross.
  function automatic meas_t make_crossing();
    real span, px, py, ax, ay, bx, by, gxr, gyr;
    span = 2.0 ** $urandom_range(29, 2);
    px = rnd_span(2.0 ** 29);
    py = rnd_span(2.0 ** 29);
    ax = px + rnd_span(span);
    ay = py + rnd_span(span);
    bx = px + rnd_span(span);
    by = py + rnd_span(span);
    if ($urandom_range(1)) begin
      gxr = px + rnd_span(span / 4.0);
      gyr = py + rnd_span(span / 4.0);
    end else begin
      gxr = rnd_span(2.0 ** 31 - 1.0);
      gyr = rnd_span(2.0 ** 31 - 1.0);
    end
    return mk(longint'(ax), longint'(ay),
              longint'($sqrt((ax - px) ** 2 + (ay - py) ** 2)),
              longint'(bx), longint'(by),
              longint'($sqrt((bx - px) ** 2 + (by - py) ** 2)),
              longint'(gxr), longint'(gyr));
  endfunction

  function automatic meas_t make_noise();
    meas_t m;
    m.c1x = $urandom;
    m.c1y = $urandom;
    m.r1 = RadW'($urandom);
    m.c2x = $urandom;
    m.c2y = $urandom;
    m.r2 = RadW'($urandom);
    m.gx = $urandom;
    m.gy = $urandom;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed;
    longint mx, mn, rmax;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    rmax = 64'sd2147483647;
    send_meas(mk(0, 0, One, One, 0, One, 0, One));               // plain crossing
    send_meas(mk(0, 0, One, One, 0, One, 0, -One));              // other point
    send_meas(mk(0, 0, One, One, 0, One, 0, 0));                 // guess on axis: tie
    send_meas(mk(0, 0, One, 4 * One, 0, One, 0, 0));             // separate
    send_meas(mk(0, 0, 10 * One, One, 0, One, 0, 0));            // nested
    send_meas(mk(0, 0, One, 2 * One, 0, One, One, One));         // tangent outside
    send_meas(mk(0, 0, 2 * One, One, 0, One, One, One));         // tangent inside
    send_meas(mk(5, 5, One, 5, 5, One, 0, 0));                   // equal centres
    send_meas(mk(0, 0, One, 5, 0, One, 0, 0));                   // under default threshold
    send_meas(mk(0, 0, One, 7, 0, One, 0, 0));                   // at default threshold
    send_meas(mk(mn, mn, rmax, mx, mx, rmax, 0, 0));             // d2 carry
    send_meas(mk(mn, mx, rmax, mx, mn, rmax, mx, mx));           // carry, other diagonal
    send_meas(mk(0, 0, rmax, One, 0, rmax, mx, mn));             // huge radii, saturation
    send_meas(mk(mx - One, 0, rmax, mx - One, One, rmax, mn, 0));
    send_meas(mk(mn, mn, 0, mn, mn, 0, mn, mn));                 // zero radii, same centre
    send_meas(mk(mn, 0, 0, mx, 0, 0, 0, 0));                     // zero radii apart
    send_meas(mk(mn, 0, rmax, mx, 0, rmax, 0, mx));              // wide, one LSB apart
    send_meas(mk(0, 0, 3 * One, 5 * One, 0, 4 * One, mx, mx));   // 3-4-5
    send_meas(mk(-One, -One, 5 * One, 2 * One, 3 * One, 2 * One, mn, mx));
    send_meas(mk(1, 1, 1, 2, 2, 1, 1, 2));                       // tiny raw values
    drain();
  endtask

  task automatic test_threshold;
    write_thresh('0);
    send_meas(mk(3, 3, One, 3, 3, One, 0, 0));                   // still coincident
    send_meas(mk(0, 0, One, 1, 0, One, 0, One));
    drain();
    write_thresh(16'hFFFF);
    send_meas(mk(0, 0, One, 65534, 0, One, 0, One));
    send_meas(mk(0, 0, One, 65535, 0, One, 0, One));
    send_meas(mk(0, 0, One, 65536, 0, One, 0, One));
    drain();
    write_thresh(16'($urandom));
    repeat (20) send_meas(make_crossing());
    drain();
    write_thresh(ThreshReset);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) begin
      if ($urandom_range(99) < 75) send_meas(make_crossing());
      else send_meas(make_noise());
    end
    drain();
  endtask

  // Result side stops for a long stretch while items keep coming, so the
  // pipe and skid fill and the block has to stall its input.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 600;
    repeat (250) send_meas(make_crossing());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold();
    test_random(450, 11, 63);
    test_random(450, 63, 11);
    test_random(450, 0, 0);
    test_backpressure();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d measurement sets, checked %0d fixes", n_sent, n_checked);
    $display("(%0d without crossing, %0d coincident), threshold 0/max/random/default",
             n_noisect, n_coinc);
    if (n_errors == 0 && fix_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cpin_pkg.sv
design/cpin_if.sv
design/cpin_sqrt.sv
design/cpin_div.sv
design/circle_pair_intersect_nearest.sv
tb/tb_top.sv
